>>> hdl/ucd_pkg.sv
package ucd_pkg;

    // Default operand and result width
    localparam int unsigned DATA_WIDTH_DEF = 32;

    // Legal range of the width parameter
    localparam int unsigned DATA_WIDTH_MIN = 2;
    localparam int unsigned DATA_WIDTH_MAX = 64;

endpackage

>>> hdl/ucd_cell.sv
module ucd_cell import ucd_pkg::*; #(
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  in_valid,
    input  logic [DATA_WIDTH-1:0] in_rem,
    input  logic [DATA_WIDTH-1:0] in_dq,
    input  logic [DATA_WIDTH-1:0] in_dsr,
    output logic                  out_valid,
    output logic [DATA_WIDTH-1:0] out_rem,
    output logic [DATA_WIDTH-1:0] out_dq,
    output logic [DATA_WIDTH-1:0] out_dsr
);

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] dq_reg;
    logic [DATA_WIDTH-1:0] dsr_reg;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] dq_next;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;

    // Bring in the next dividend bit and try to subtract the divisor
    always_comb begin
        trial    = {in_rem, in_dq[DATA_WIDTH-1]};
        diff     = trial - {1'b0, in_dsr};
        fits     = ~diff[DATA_WIDTH];
        rem_next = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
        // Shift the dividend out at the top, the quotient bit in at the bottom
        dq_next  = {in_dq[DATA_WIDTH-2:0], fits};
    end

    // Advance the request flag together with the whole chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    // Hold the partial remainder and operands while stalled
    always_ff @(posedge aclk) begin
        if (advance) begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
            dsr_reg <= in_dsr;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_dq    = dq_reg;
    assign out_dsr   = dsr_reg;

endmodule

>>> hdl/ucd_out.sv
module ucd_out import ucd_pkg::*; #(
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  in_valid,
    input  logic [DATA_WIDTH-1:0] in_rem,
    input  logic [DATA_WIDTH-1:0] in_quo,
    input  logic [DATA_WIDTH-1:0] in_dsr,
    output logic                  m_valid,
    output logic [DATA_WIDTH-1:0] m_quotient_ceiling
);

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] quo_next;
    logic                  rem_nz;

    // Round up on a nonzero remainder; force zero for a zero divisor
    always_comb begin
        rem_nz = |in_rem;
        if (in_dsr == '0) begin
            quo_next = '0;
        end else begin
            quo_next = in_quo + {{(DATA_WIDTH-1){1'b0}}, rem_nz};
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            quo_reg <= quo_next;
        end
    end

    assign m_valid            = valid_reg;
    assign m_quotient_ceiling = quo_reg;

endmodule

>>> hdl/unsigned_ceiling_divider.sv
// Channel | Ports                                   | Handshake
// --------+-----------------------------------------+----------------
// input   | s_dividend, s_divisor                   | s_valid/s_ready
// result  | m_quotient_ceiling                      | m_valid/m_ready
//
// One request enters per cycle while the chain advances; its result passes through
// one restoring-division cell per quotient bit, then the rounding output register.
// Reset (aresetn, synchronous, active low) clears every stage's valid flag.
// The whole chain advances only when the output register is empty or taken,
// so a stalled consumer freezes all requests in flight; s_ready follows that.
module unsigned_ceiling_divider import ucd_pkg::*; #(
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DATA_WIDTH-1:0] s_dividend,
    input  logic [DATA_WIDTH-1:0] s_divisor,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_WIDTH-1:0] m_quotient_ceiling
);

    logic                  advance;
    logic                  valid_w [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] rem_w   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] dq_w    [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] dsr_w   [0:DATA_WIDTH];

    // Advance the chain when the output slot is free or being drained
    assign advance = ~m_valid | m_ready;
    assign s_ready = advance;

    // Feed a new request into the first cell
    assign valid_w[0] = s_valid;
    assign rem_w[0]   = '0;
    assign dq_w[0]    = s_dividend;
    assign dsr_w[0]   = s_divisor;

    // One cell per quotient bit, most significant first
    for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
        ucd_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .in_valid (valid_w[i]),
            .in_rem   (rem_w[i]),
            .in_dq    (dq_w[i]),
            .in_dsr   (dsr_w[i]),
            .out_valid(valid_w[i+1]),
            .out_rem  (rem_w[i+1]),
            .out_dq   (dq_w[i+1]),
            .out_dsr  (dsr_w[i+1])
        );
    end

    // Round up and register the result
    ucd_out #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_out (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .advance           (advance),
        .in_valid          (valid_w[DATA_WIDTH]),
        .in_rem            (rem_w[DATA_WIDTH]),
        .in_quo            (dq_w[DATA_WIDTH]),
        .in_dsr            (dsr_w[DATA_WIDTH]),
        .m_valid           (m_valid),
        .m_quotient_ceiling(m_quotient_ceiling)
    );

endmodule

>>> test/ceil_div_checker.sv
`timescale 1ns / 1ps

module ceil_div_checker import ucd_pkg::*; #(
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [DATA_WIDTH-1:0] s_dividend,
    input  logic [DATA_WIDTH-1:0] s_divisor,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [DATA_WIDTH-1:0] m_quotient_ceiling,
    output int unsigned           mismatches,
    output int unsigned           in_flight,
    output int unsigned           quotients_checked
);

    typedef struct packed {
        logic [DATA_WIDTH-1:0] num;
        logic [DATA_WIDTH-1:0] den;
        logic [DATA_WIDTH-1:0] quot;
    } division_t;

    division_t quotient_due[$];

    initial begin
        mismatches        = 0;
        in_flight         = 0;
        quotients_checked = 0;
    end

    // Round the truncating quotient up when anything is left over
    function automatic logic [DATA_WIDTH-1:0] ceil_quotient(
        input logic [DATA_WIDTH-1:0] num,
        input logic [DATA_WIDTH-1:0] den
    );
        logic [DATA_WIDTH-1:0] q;
        if (den == '0) begin
            return '0;
        end
        q = num / den;
        if ((num % den) != '0) begin
            q = q + 1'b1;
        end
        return q;
    endfunction

    // Predict on each accepted request, compare each accepted result in order
    always @(posedge aclk) begin
        division_t exp_div;
        if (!aresetn) begin
            quotient_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (quotient_due.size() == 0) begin
                    $display("%0t: result %0d arrived with no request outstanding",
                             $time, m_quotient_ceiling);
                    mismatches <= mismatches + 1;
                end else begin
                    exp_div = quotient_due.pop_front();
                    if (m_quotient_ceiling !== exp_div.quot) begin
                        $display("%0t: quotient_ceiling wrong for %0d / %0d: expected %0d, got %0d",
                                 $time, exp_div.num, exp_div.den, exp_div.quot,
                                 m_quotient_ceiling);
                        mismatches <= mismatches + 1;
                    end
                    quotients_checked <= quotients_checked + 1;
                end
            end
            if (s_valid && s_ready) begin
                exp_div.num  = s_dividend;
                exp_div.den  = s_divisor;
                exp_div.quot = ceil_quotient(s_dividend, s_divisor);
                quotient_due.push_back(exp_div);
            end
        end
        in_flight <= quotient_due.size();
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ucd_pkg::*;

    localparam int unsigned W          = DATA_WIDTH_DEF;
    localparam int unsigned LATENCY    = W + 1;
    localparam int unsigned N_RANDOM   = 450;
    localparam int unsigned CYCLE_CAP  = 200000;
    localparam logic [W-1:0] ALL_ONES  = '1;
    localparam logic [W-1:0] TOP_BIT   = {1'b1, {(W-1){1'b0}}};

    typedef enum {
        RX_OPEN,
        RX_BUSY,
        RX_HALF,
        RX_CHOKED
    } rx_mode_t;

    typedef enum {
        OP_FULL,
        OP_SMALL_DEN,
        OP_ZERO_DEN,
        OP_ZERO_NUM,
        OP_EXACT,
        OP_NEAR_EXACT,
        OP_DEN_ABOVE,
        OP_SCALED
    } operand_shape_t;

    logic         aclk    = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [W-1:0] s_dividend = '0;
    logic [W-1:0] s_divisor  = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [W-1:0] m_quotient_ceiling;

    int unsigned mismatches;
    int unsigned in_flight;
    int unsigned quotients_checked;
    int unsigned cycles       = 0;
    int unsigned requests_sent = 0;
    int unsigned burst_left   = 0;

    rx_mode_t    rx_mode   = RX_OPEN;
    int unsigned rx_left   = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    unsigned_ceiling_divider #(
        .DATA_WIDTH(W)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_dividend        (s_dividend),
        .s_divisor         (s_divisor),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_quotient_ceiling(m_quotient_ceiling)
    );

    ceil_div_checker #(
        .DATA_WIDTH(W)
    ) checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_dividend        (s_dividend),
        .s_divisor         (s_divisor),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_quotient_ceiling(m_quotient_ceiling),
        .mismatches        (mismatches),
        .in_flight         (in_flight),
        .quotients_checked (quotients_checked)
    );

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Stall the result channel, switching to a randomly chosen pattern after each random-length run
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 120);
        end
        rx_left = rx_left - 1;
        case (rx_mode)
            RX_OPEN:  m_ready <= 1'b1;
            RX_BUSY:  m_ready <= ($urandom_range(0, 3) != 0);
            RX_HALF:  m_ready <= ($urandom_range(0, 1) == 0);
            default:  m_ready <= ((rx_left % 9) == 0);
        endcase
    end

    function automatic logic [W-1:0] rand_word();
        logic [W+31:0] acc;
        acc = '0;
        for (int i = 0; i < W; i += 32) begin
            acc = (acc << 32) | $urandom;
        end
        return acc[W-1:0];
    endfunction

    function automatic logic [W-1:0] rand_scaled();
        return rand_word() >> $urandom_range(0, W - 1);
    endfunction

    // Present one request, hold it until taken, then pace the next burst
    task automatic send_division(input logic [W-1:0] num, input logic [W-1:0] den);
        int unsigned gap;
        s_dividend <= num;
        s_divisor  <= den;
        s_valid    <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        requests_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    endtask

    // Hold off new requests until the pipeline is empty
    task automatic drain_divider();
        s_valid <= 1'b0;
        while (in_flight != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Build operands of a randomly chosen shape
    task automatic send_random_division();
        operand_shape_t shape;
        logic [W-1:0]   num;
        logic [W-1:0]   den;
        logic [W-1:0]   k;
        shape = operand_shape_t'($urandom_range(0, 7));
        num = rand_word();
        den = rand_word();
        case (shape)
            OP_FULL: ;
            OP_SMALL_DEN: den = $urandom_range(1, 16);
            OP_ZERO_DEN: begin
                den = '0;
                num = rand_scaled();
            end
            OP_ZERO_NUM: begin
                num = '0;
                den = rand_scaled();
            end
            OP_EXACT, OP_NEAR_EXACT: begin
                den = rand_word() >> $urandom_range(W / 2, W - 1);
                if (den == '0) begin
                    den = 1;
                end
                k   = rand_word() % (ALL_ONES / den);
                num = den * k;
                if (shape == OP_NEAR_EXACT) begin
                    num = ($urandom_range(0, 1) == 0) ? num + 1'b1 : num - 1'b1;
                end
            end
            OP_DEN_ABOVE: begin
                num = rand_scaled();
                den = num + rand_scaled() + 1'b1;
            end
            default: begin
                num = rand_scaled();
                den = rand_scaled();
            end
        endcase
        send_division(num, den);
    endtask

    initial begin
        int unsigned directed;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Corners: zero operands, full-scale values, exact and rounded quotients
        send_division('0, '0);
        send_division('0, 1);
        send_division('0, ALL_ONES);
        send_division(ALL_ONES, '0);
        send_division(1, '0);
        send_division(ALL_ONES, 1);
        send_division(ALL_ONES, ALL_ONES);
        send_division(1, ALL_ONES);
        send_division(ALL_ONES, ALL_ONES - 1'b1);
        send_division(ALL_ONES - 1'b1, ALL_ONES);
        send_division(10, 5);
        send_division(11, 5);
        send_division(9, 5);
        send_division(7, 2);
        send_division(TOP_BIT, 2);
        send_division(TOP_BIT + 1'b1, 2);
        send_division(ALL_ONES, 2);
        send_division(1, 1);
        send_division(5, 10);
        send_division({(W/2){2'b10}}, {(W/2){2'b01}});
        send_division({(W/2){2'b01}}, {(W/2){2'b10}});
        send_division(ALL_ONES, TOP_BIT);
        send_division(TOP_BIT, TOP_BIT + 1'b1);
        directed = requests_sent;
        drain_divider();

        for (int i = 0; i < N_RANDOM; i++) begin
            send_random_division();
            if (i == N_RANDOM / 2) begin
                drain_divider();
            end
        end

        // Wait out every outstanding result, then a little longer
        s_valid <= 1'b0;
        while (in_flight != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);

        $display("Sent %0d division requests (%0d directed corners) and checked %0d quotients,",
                 requests_sent, directed, quotients_checked);
        $display("covering zero operands, exact and rounded quotients under random stalls.");
        if (mismatches == 0 && in_flight == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
